// ===== rtl/weather_meter_pulse_and_vane_unit_top_macros.svh =====
// Assertion macros for the weather meter pulse and vane unit.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef WEATHER_METER_PULSE_AND_VANE_UNIT_TOP_MACROS_SVH
`define WEATHER_METER_PULSE_AND_VANE_UNIT_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define WMPV_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled during reset.
`define WMPV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define WMPV_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define WMPV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/wmpv_pkg.sv =====
// Package for the weather meter pulse and vane unit: widths, codes, item types,
// shared-unit request/response structs and the vane sector ratio table. No dependencies.
`default_nettype none
package wmpv_pkg;

    localparam int COUNT_BITS = 16;
    localparam int SECTORS    = 16;
    localparam int SEC_W      = $clog2(SECTORS);

    localparam int MV_W      = 12;
    localparam int RATIO_W   = 16;
    localparam int Q_SHIFT   = 16;
    localparam int ELAPSED_W = 32;
    localparam int RAIN_W    = 28;
    localparam int WIND_W    = 36;
    localparam int IDX_W     = 4;
    localparam int DEG_W     = 12;
    localparam int REQ_W     = 3;
    localparam int KIND_W    = 2;

    // Shared multiplier and subtractor widths.
    localparam int MUL_A_W  = 32;
    localparam int MUL_B_W  = 21;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int NUM_W    = COUNT_BITS + MUL_B_W;
    localparam int DEN_W    = ELAPSED_W + 2;
    localparam int SUB_W    = DEN_W + 1;
    localparam int CNT_W    = $clog2(NUM_W);
    localparam int RAIN_P_W = COUNT_BITS + 12;
    localparam int DIST_W   = MV_W + RATIO_W;

    localparam logic [MUL_B_W-1:0] RAIN_PER_PULSE = MUL_B_W'(2794);
    localparam logic [MUL_B_W-1:0] WIND_NUM       = MUL_B_W'(2000000);
    localparam logic [MUL_B_W-1:0] WIND_DEN       = MUL_B_W'(3);
    localparam int                 DECIDEG_PER_SECTOR = 225;

    localparam logic [RAIN_W-1:0] RAIN_MAX = '1;
    localparam logic [WIND_W-1:0] WIND_MAX = '1;

    localparam logic [REQ_W-1:0] REQ_RAIN_PULSE = 3'd0;
    localparam logic [REQ_W-1:0] REQ_WIND_PULSE = 3'd1;
    localparam logic [REQ_W-1:0] REQ_MS_TICK    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_READ_RAIN  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_READ_WIND  = 3'd4;
    localparam logic [REQ_W-1:0] REQ_VANE       = 3'd5;

    localparam logic [KIND_W-1:0] KIND_RAIN = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WIND = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DIR  = 2'd2;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [MV_W-1:0]  vane_mv;
        logic [MV_W-1:0]  supply_mv;
    } t_in_item;

    typedef struct packed {
        logic [KIND_W-1:0] result_kind;
        logic [RAIN_W-1:0] rainfall_tenth_um;
        logic [WIND_W-1:0] wind_speed_mmps;
        logic [IDX_W-1:0]  direction_index;
        logic [DEG_W-1:0]  direction_decideg;
    } t_out_item;

    typedef struct packed {
        logic               mul_en;
        logic [MUL_A_W-1:0] mul_a;
        logic [MUL_B_W-1:0] mul_b;
        logic [SUB_W-1:0]   sub_a;
        logic [SUB_W-1:0]   sub_b;
        logic               abs_mode;
    } t_alu_req;

    typedef struct packed {
        logic [PROD_W-1:0] prod;
        logic [SUB_W-1:0]  diff;
        logic              borrow;
    } t_alu_rsp;

    // Q16 divider ratio R2/(4700+R2), rounded half up, for each sector.
    function automatic logic [RATIO_W-1:0] q16_ratio(input logic [SEC_W-1:0] sec);
        logic [RATIO_W-1:0] r;
        case (sec)
            4'd0:    r = 16'd57366;
            4'd1:    r = 16'd38205;
            4'd2:    r = 16'd41659;
            4'd3:    r = 16'd10444;
            4'd4:    r = 16'd11498;
            4'd5:    r = 16'd8368;
            4'd6:    r = 16'd20896;
            4'd7:    r = 16'd15124;
            4'd8:    r = 16'd29720;
            4'd9:    r = 16'd26248;
            4'd10:   r = 16'd50656;
            4'd11:   r = 16'd49169;
            4'd12:   r = 16'd63066;
            4'd13:   r = 16'd58957;
            4'd14:   r = 16'd61110;
            4'd15:   r = 16'd53948;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/wmpv_if.sv =====
// Valid/ready channel interfaces for input items and result items.
// Depends on wmpv_pkg for the payload types.
`default_nettype none
interface wmpv_in_if;
    import wmpv_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface wmpv_out_if;
    import wmpv_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/wmpv_alu.sv =====
// Shared arithmetic unit: one registered multiplier and one subtractor with
// optional absolute value. Depends on wmpv_pkg.
`default_nettype none
module wmpv_alu (
    input  wire                  i_clk,
    input  wmpv_pkg::t_alu_req   i_req,
    output wmpv_pkg::t_alu_rsp   o_rsp
);
    import wmpv_pkg::*;

    logic [PROD_W-1:0] r_prod;
    logic [SUB_W:0]    w_sum;
    logic [SUB_W-1:0]  w_neg;

    // Hold the product until the next multiply.
    always_ff @(posedge i_clk) begin
        if (i_req.mul_en) begin
            r_prod <= PROD_W'(i_req.mul_a) * PROD_W'(i_req.mul_b);
        end
    end

    always_comb begin
        w_sum = {1'b0, i_req.sub_a} - {1'b0, i_req.sub_b};
        w_neg = ~w_sum[SUB_W-1:0] + SUB_W'(1);
        o_rsp.prod   = r_prod;
        o_rsp.borrow = w_sum[SUB_W];
        o_rsp.diff   = (i_req.abs_mode && w_sum[SUB_W]) ? w_neg : w_sum[SUB_W-1:0];
    end

endmodule
`default_nettype wire

// ===== rtl/wmpv_ctrl.sv =====
// Sequencer, pulse/tick counters and working registers of the weather meter unit.
// Drives the shared unit wmpv_alu; depends on wmpv_pkg and the assertion macros.
`default_nettype none
`include "weather_meter_pulse_and_vane_unit_top_macros.svh"
module wmpv_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_acc,
    input  wmpv_pkg::t_in_item   i_item,
    input  wire                  i_take,
    output logic                 o_idle,
    output logic                 o_res_valid,
    output wmpv_pkg::t_out_item  o_res
);
    import wmpv_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_RMUL  = 4'd1;
    localparam logic [3:0] ST_RSAT  = 4'd2;
    localparam logic [3:0] ST_WMUL  = 4'd3;
    localparam logic [3:0] ST_WDMUL = 4'd4;
    localparam logic [3:0] ST_WINIT = 4'd5;
    localparam logic [3:0] ST_WDIV  = 4'd6;
    localparam logic [3:0] ST_WDONE = 4'd7;
    localparam logic [3:0] ST_VMUL  = 4'd8;
    localparam logic [3:0] ST_VABS  = 4'd9;
    localparam logic [3:0] ST_VCMP  = 4'd10;
    localparam logic [3:0] ST_VFIN  = 4'd11;
    localparam logic [3:0] ST_DONE  = 4'd12;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX   = '1;
    localparam logic [ELAPSED_W-1:0]  ELAPSED_MAX = '1;

    logic [3:0]            r_state, n_state;
    logic [COUNT_BITS-1:0] r_rain, n_rain;
    logic [COUNT_BITS-1:0] r_wind, n_wind;
    logic [ELAPSED_W-1:0]  r_elapsed, n_elapsed;
    logic [MV_W-1:0]       r_vane, n_vane;
    logic [MV_W-1:0]       r_supply, n_supply;
    logic [SEC_W-1:0]      r_sector, n_sector;
    logic [SEC_W-1:0]      r_idx, n_idx;
    logic [SUB_W-1:0]      r_dist, n_dist;
    logic [SUB_W-1:0]      r_best, n_best;
    logic [NUM_W-1:0]      r_quo, n_quo;
    logic [DEN_W-1:0]      r_den, n_den;
    logic [SUB_W-1:0]      r_rem, n_rem;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    t_out_item             r_res, n_res;

    t_alu_req              w_req;
    t_alu_rsp              w_rsp;
    logic [SUB_W-1:0]      w_shift;
    logic [RAIN_P_W-1:0]   w_rain_prod;

    wmpv_alu u_alu (
        .i_clk (i_clk),
        .i_req (w_req),
        .o_rsp (w_rsp)
    );

    assign o_idle      = (r_state == ST_IDLE);
    assign o_res_valid = (r_state == ST_DONE);
    assign o_res       = r_res;

    assign w_shift     = {r_rem[SUB_W-2:0], r_quo[NUM_W-1]};
    assign w_rain_prod = w_rsp.prod[RAIN_P_W-1:0];

    always_comb begin
        n_state   = r_state;
        n_rain    = r_rain;
        n_wind    = r_wind;
        n_elapsed = r_elapsed;
        n_vane    = r_vane;
        n_supply  = r_supply;
        n_sector  = r_sector;
        n_idx     = r_idx;
        n_dist    = r_dist;
        n_best    = r_best;
        n_quo     = r_quo;
        n_den     = r_den;
        n_rem     = r_rem;
        n_cnt     = r_cnt;
        n_res     = r_res;
        w_req     = '0;

        case (r_state)
            ST_IDLE: begin
                if (i_acc) begin
                    case (i_item.req_type)
                        REQ_RAIN_PULSE: begin
                            if (r_rain != COUNT_MAX) n_rain = r_rain + 1'b1;
                        end
                        REQ_WIND_PULSE: begin
                            if (r_wind != COUNT_MAX) n_wind = r_wind + 1'b1;
                        end
                        REQ_MS_TICK: begin
                            if (r_elapsed != ELAPSED_MAX) n_elapsed = r_elapsed + 1'b1;
                        end
                        REQ_READ_RAIN: begin
                            n_state = ST_RMUL;
                        end
                        REQ_READ_WIND: begin
                            if (r_elapsed == '0) begin
                                // No time base yet: report zero, keep the counts.
                                n_res             = '0;
                                n_res.result_kind = KIND_WIND;
                                n_state           = ST_DONE;
                            end else begin
                                n_state = ST_WMUL;
                            end
                        end
                        REQ_VANE: begin
                            n_vane   = i_item.vane_mv;
                            n_supply = i_item.supply_mv;
                            n_sector = '0;
                            n_idx    = '0;
                            n_best   = '1;
                            n_state  = ST_VMUL;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RMUL: begin
                w_req.mul_en = 1'b1;
                w_req.mul_a  = MUL_A_W'(r_rain);
                w_req.mul_b  = RAIN_PER_PULSE;
                n_state      = ST_RSAT;
            end
            ST_RSAT: begin
                n_res             = '0;
                n_res.result_kind = KIND_RAIN;
                if (64'(w_rain_prod) > 64'(RAIN_MAX)) begin
                    n_res.rainfall_tenth_um = RAIN_MAX;
                end else begin
                    n_res.rainfall_tenth_um = RAIN_W'(w_rain_prod);
                end
                n_rain  = '0;
                n_state = ST_DONE;
            end
            ST_WMUL: begin
                w_req.mul_en = 1'b1;
                w_req.mul_a  = MUL_A_W'(r_wind);
                w_req.mul_b  = WIND_NUM;
                n_state      = ST_WDMUL;
            end
            ST_WDMUL: begin
                n_quo        = w_rsp.prod[NUM_W-1:0];
                w_req.mul_en = 1'b1;
                w_req.mul_a  = MUL_A_W'(r_elapsed);
                w_req.mul_b  = WIND_DEN;
                n_state      = ST_WINIT;
            end
            ST_WINIT: begin
                n_den   = w_rsp.prod[DEN_W-1:0];
                n_rem   = '0;
                n_cnt   = CNT_W'(NUM_W - 1);
                n_state = ST_WDIV;
            end
            ST_WDIV: begin
                // One restoring step: shift in the next dividend bit, try the subtract.
                w_req.sub_a = w_shift;
                w_req.sub_b = SUB_W'(r_den);
                if (w_rsp.borrow) begin
                    n_rem = w_shift;
                    n_quo = {r_quo[NUM_W-2:0], 1'b0};
                end else begin
                    n_rem = w_rsp.diff;
                    n_quo = {r_quo[NUM_W-2:0], 1'b1};
                end
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) n_state = ST_WDONE;
            end
            ST_WDONE: begin
                n_res             = '0;
                n_res.result_kind = KIND_WIND;
                if (64'(r_quo) > 64'(WIND_MAX)) begin
                    n_res.wind_speed_mmps = WIND_MAX;
                end else begin
                    n_res.wind_speed_mmps = WIND_W'(r_quo);
                end
                n_wind    = '0;
                n_elapsed = '0;
                n_state   = ST_DONE;
            end
            ST_VMUL: begin
                w_req.mul_en = 1'b1;
                w_req.mul_a  = MUL_A_W'(q16_ratio(r_sector));
                w_req.mul_b  = MUL_B_W'(r_supply);
                n_state      = ST_VABS;
            end
            ST_VABS: begin
                w_req.sub_a    = SUB_W'({r_vane, {Q_SHIFT{1'b0}}});
                w_req.sub_b    = SUB_W'(w_rsp.prod[DIST_W-1:0]);
                w_req.abs_mode = 1'b1;
                n_dist         = w_rsp.diff;
                n_state        = ST_VCMP;
            end
            ST_VCMP: begin
                // Strictly smaller wins, so the first minimum is kept.
                w_req.sub_a = r_dist;
                w_req.sub_b = r_best;
                if (w_rsp.borrow) begin
                    n_best = r_dist;
                    n_idx  = r_sector;
                end
                if (r_sector == SEC_W'(SECTORS - 1)) begin
                    n_state = ST_VFIN;
                end else begin
                    n_sector = r_sector + 1'b1;
                    n_state  = ST_VMUL;
                end
            end
            ST_VFIN: begin
                n_res                   = '0;
                n_res.result_kind       = KIND_DIR;
                n_res.direction_index   = IDX_W'(r_idx);
                n_res.direction_decideg = DEG_W'(r_idx * DECIDEG_PER_SECTOR);
                n_state                 = ST_DONE;
            end
            ST_DONE: begin
                if (i_take) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_rain    <= '0;
            r_wind    <= '0;
            r_elapsed <= '0;
        end else begin
            r_state   <= n_state;
            r_rain    <= n_rain;
            r_wind    <= n_wind;
            r_elapsed <= n_elapsed;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vane   <= n_vane;
        r_supply <= n_supply;
        r_sector <= n_sector;
        r_idx    <= n_idx;
        r_dist   <= n_dist;
        r_best   <= n_best;
        r_quo    <= n_quo;
        r_den    <= n_den;
        r_rem    <= n_rem;
        r_cnt    <= n_cnt;
        r_res    <= n_res;
    end

    `WMPV_ASSERT_IMP(a_rem_below_den, i_clk, i_rst_n, r_state == ST_WDIV, r_rem < SUB_W'(r_den), "divider remainder not below divisor")
    `WMPV_ASSERT_NEXT(a_wind_cleared, i_clk, i_rst_n, r_state == ST_WDONE, r_wind == '0 && r_elapsed == '0, "wind read did not clear counters")
    `WMPV_ASSERT_NEXT(a_take_to_idle, i_clk, i_rst_n, o_res_valid && i_take, r_state == ST_IDLE && r_res == $past(r_res), "result hand-off did not return to idle")

endmodule
`default_nettype wire

// ===== rtl/weather_meter_pulse_and_vane_unit_top.sv =====
// Top level of the weather meter pulse and vane unit: input handshake,
// sequencer with shared arithmetic unit, and output register.
// Depends on wmpv_pkg, wmpv_if, wmpv_ctrl and the assertion macros.
//
// Usage:
//   i_in carries one event beat: rain pulse, wind pulse, ms tick, read rain,
//   read wind speed or vane sample. o_out carries one result beat for each
//   read or vane sample; pulses, ticks and unknown codes give no beat.
//   Pulses and ticks are taken while the sequencer stays idle, so ready stays high.
//   Read rain: one multiply plus saturation.
//   Read wind: two multiplies, then a restoring divider that retires one
//   quotient bit per cycle (COUNT_BITS+21 bits, 37 at default).
//   A read with no ms tick since the last clearing read returns 0 without the divider.
//   Vane sample: 16 sectors, each taken through the shared multiplier and
//   subtractor in order (product, distance, compare).
//   One item is in work at a time; i_in.ready is low until its result beat
//   has moved into the output register.
//   Stall: the output register holds its beat while o_out.ready is low; a new
//   item may be accepted and worked on meanwhile, and its result waits in the
//   sequencer until the register frees up.
//   Reset (i_rst_n low, synchronous) clears the counters and drops o_out.valid.
`default_nettype none
`include "weather_meter_pulse_and_vane_unit_top_macros.svh"
module weather_meter_pulse_and_vane_unit_top (
    input  wire           i_clk,
    input  wire           i_rst_n,
    wmpv_in_if.sink       i_in,
    wmpv_out_if.source    o_out
);
    import wmpv_pkg::*;

    logic      w_idle;
    logic      w_res_valid;
    t_out_item w_res;
    logic      w_acc;
    logic      w_take;

    logic      r_out_valid;
    t_out_item r_out_data;

    assign i_in.ready = w_idle;
    assign w_acc      = i_in.valid && w_idle;

    // Move the finished beat into the output register once it is free.
    assign w_take = w_res_valid && (!r_out_valid || o_out.ready);

    wmpv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (w_acc),
        .i_item      (i_in.data),
        .i_take      (w_take),
        .o_idle      (w_idle),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_data <= w_res;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    `WMPV_ASSERT_IMP(a_no_accept_while_busy, i_clk, i_rst_n, w_res_valid, !i_in.ready, "input accepted while a result is pending")
    `WMPV_ASSERT_NEXT(a_take_loads_out, i_clk, i_rst_n, w_take, r_out_valid && r_out_data == $past(w_res), "result beat not loaded into output register")
    `WMPV_ASSERT_IMP(a_kind_known, i_clk, i_rst_n, r_out_valid, r_out_data.result_kind == KIND_RAIN || r_out_data.result_kind == KIND_WIND || r_out_data.result_kind == KIND_DIR, "unknown result kind on output")

endmodule
`default_nettype wire
